// ----- rtl/vfd_pkg.sv -----
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, constants and helper functions of the varint field decoder.
// ----------------------------------------------------------------------------
package vfd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned COUNT_W   = 4;
	localparam int unsigned GROUP_W   = 7;
	localparam int unsigned SHIFT_W   = 7;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
	localparam logic [COUNT_W-1:0] LSB_POS_MAX = 4'd9;    // last group that still lands
	localparam logic [1:0]         LOW_PAIR    = 2'b11;
	localparam logic [31:0]        MAP_HIGH    = 32'hC000_0000;
	localparam int unsigned        CONT_BIT    = 7;

	localparam logic [APB_ADDR_W-1:0] ADDR_GROUP_ORDER = 3'd0;

	typedef enum logic [MODE_W-1:0] {
		KIND_BYTE = 2'd0,
		KIND_I32  = 2'd1,
		KIND_I64  = 2'd2
	} kind_t;

	typedef enum logic {
		ORDER_LSB_FIRST = 1'b0,
		ORDER_MSB_FIRST = 1'b1
	} order_t;

	// One classified byte, handed from the front to the back
	typedef struct packed {
		kind_t              kind;
		logic               first;
		logic               last;
		order_t             order;
		logic [COUNT_W-1:0] pos;
		logic [BYTE_W-1:0]  data;
	} vfd_tag_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [31:0] map_int32(input logic [31:0] n);
		logic [31:0] inv;
		inv = ~n;
		if (n[1:0] == LOW_PAIR)
			return MAP_HIGH | {2'b00, inv[31:2]};
		else
			return {n[1:0], n[31:2]};
	endfunction

endpackage

// ----- rtl/vfd_if.sv -----
// ----------------------------------------------------------------------------
// vfd_byte_if / vfd_result_if
// Valid/ready channels of the decoder: serialized bytes in, values out.
// ----------------------------------------------------------------------------
interface vfd_byte_if import vfd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   data_byte;
	logic [MODE_W-1:0]   mode;

	modport source (output valid, data_byte, mode, input ready);
	modport sink   (input valid, data_byte, mode, output ready);
endinterface

interface vfd_result_if import vfd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [MODE_W-1:0]   kind;
	logic [COUNT_W-1:0]  byte_count;

	modport source (output valid, value, kind, byte_count, input ready);
	modport sink   (input valid, value, kind, byte_count, output ready);
endinterface

// ----- rtl/vfd_front.sv -----
// ----------------------------------------------------------------------------
// vfd_front
// Accept bytes, track value boundaries and tag each byte for the back end.
// ----------------------------------------------------------------------------
module vfd_front import vfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vfd_byte_if.sink    byte_in,
	input  order_t      group_order,
	input  logic        q_ready,
	output logic        q_push,
	output vfd_tag_t    q_tag
);

	logic               in_value_q;
	kind_t              kind_q;
	logic [COUNT_W-1:0] pos_q;
	kind_t              kind_d;
	logic               cont;

	assign byte_in.ready = q_ready;
	assign q_push        = byte_in.valid && q_ready;
	assign cont          = byte_in.data_byte[CONT_BIT];

	// sample the kind only at the first byte; unknown modes count as raw bytes
	always_comb begin
		if (in_value_q) begin
			kind_d = kind_q;
		end else begin
			unique case (byte_in.mode)
				KIND_I32: kind_d = KIND_I32;
				KIND_I64: kind_d = KIND_I64;
				default:  kind_d = KIND_BYTE;
			endcase
		end
	end

	always_comb begin
		q_tag.kind  = kind_d;
		q_tag.first = !in_value_q;
		q_tag.last  = (kind_d == KIND_BYTE) || !cont;
		q_tag.order = group_order;
		q_tag.pos   = in_value_q ? pos_q : '0;
		q_tag.data  = byte_in.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q <= 1'b0;
			kind_q     <= KIND_BYTE;
			pos_q      <= '0;
		end else if (q_push) begin
			if (q_tag.last) begin
				in_value_q <= 1'b0;
				kind_q     <= KIND_BYTE;
				pos_q      <= '0;
			end else begin
				in_value_q <= 1'b1;
				kind_q     <= kind_d;
				pos_q      <= sat_inc(q_tag.pos);
			end
		end
	end

endmodule

// ----- rtl/vfd_queue.sv -----
// ----------------------------------------------------------------------------
// vfd_queue
// Small FIFO of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module vfd_queue import vfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  vfd_tag_t  push_tag,
	output logic      ready,
	input  logic      pop,
	output logic      avail,
	output vfd_tag_t  head
);

	vfd_tag_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign ready = (fill_q != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign avail = (fill_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/vfd_back.sv -----
// ----------------------------------------------------------------------------
// vfd_back
// Fold tagged bytes into the accumulator and register finished values.
// ----------------------------------------------------------------------------
module vfd_back import vfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  vfd_tag_t      head,
	output logic          pop,
	vfd_result_if.source  result_out
);

	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] acc_base;
	logic [VALUE_W-1:0] acc_raw;
	logic [VALUE_W-1:0] acc_next;
	logic [VALUE_W-1:0] payload;
	logic [SHIFT_W-1:0] shift_amt;
	logic [VALUE_W-1:0] res_value;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [MODE_W-1:0]  kind_q;
	logic [COUNT_W-1:0] count_q;

	// take the head whenever the output slot is free or being drained
	assign pop = avail && (!out_valid_q || result_out.ready);

	assign payload   = {{(VALUE_W-GROUP_W){1'b0}}, head.data[GROUP_W-1:0]};
	assign shift_amt = SHIFT_W'(head.pos) * SHIFT_W'(GROUP_W);

	always_comb begin
		acc_base = head.first ? '0 : acc_q;
		if (head.order == ORDER_MSB_FIRST) begin
			acc_raw = {acc_base[VALUE_W-GROUP_W-1:0], head.data[GROUP_W-1:0]};
		end else if (head.pos <= LSB_POS_MAX) begin
			acc_raw = acc_base | (payload << shift_amt[5:0]);
		end else begin
			acc_raw = acc_base;
		end
		acc_next = (head.kind == KIND_I32) ? {32'b0, acc_raw[31:0]} : acc_raw;
		unique case (head.kind)
			KIND_I32: res_value = {32'b0, map_int32(acc_next[31:0])};
			KIND_I64: res_value = acc_next;
			default:  res_value = {{(VALUE_W-BYTE_W){1'b0}}, head.data};
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= acc_next;
		end
		if (pop && head.last) begin
			value_q <= res_value;
			kind_q  <= head.kind;
			count_q <= sat_inc(head.pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.value      = value_q;
	assign result_out.kind       = kind_q;
	assign result_out.byte_count = count_q;

endmodule

// ----- rtl/varint_field_decoder.sv -----
// ----------------------------------------------------------------------------
// varint_field_decoder
// Byte-serial decoder of variable-length integer fields in a trace stream.
// ----------------------------------------------------------------------------
// Feed one byte per beat on byte_in; the mode is sampled at the first byte of
// every value (0 or 3: raw byte, 1: mapped int32, 2: int64) and ignored after
// that. Integer bytes carry 7 payload bits and a continuation flag in bit 7;
// the value completes on the first byte with bit 7 clear, and one result beat
// appears on result_out with the value, its kind and the byte count
// (saturating at 15). The group_order register (APB address 0, bit 0) picks
// least or most significant group first; write it only while the block is
// idle. The block sustains one byte per clock while results are taken: the
// front tags bytes in the accept cycle, a four-entry queue decouples it from
// the back, and the back folds one byte per cycle into the accumulator
// with a single shift-or. A result beat passes through the queue and then
// the output register before it goes valid; a stalled output only stops the
// input once the queue fills.
// ----------------------------------------------------------------------------
module varint_field_decoder import vfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	vfd_byte_if.sink              byte_in,
	vfd_result_if.source          result_out
);

	order_t   group_order_q;
	logic     q_ready;
	logic     q_push;
	vfd_tag_t q_tag;
	logic     q_pop;
	logic     q_avail;
	vfd_tag_t q_head;

	// APB: zero-wait, write in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_GROUP_ORDER) ?
		{{(APB_DATA_W-1){1'b0}}, group_order_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_order_q <= ORDER_LSB_FIRST;
		end else if (psel && penable && pwrite && paddr == ADDR_GROUP_ORDER) begin
			group_order_q <= order_t'(pwdata[0]);
		end
	end

	// Front: accept and classify bytes
	vfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.group_order (group_order_q),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_tag       (q_tag)
	);

	// Queue: let each side stall on its own
	vfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tag (q_tag),
		.ready    (q_ready),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	// Back: accumulate and present results
	vfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (q_avail),
		.head       (q_head),
		.pop        (q_pop),
		.result_out (result_out)
	);

endmodule

// ----- rtl/vfd_checker.sv -----
// ----------------------------------------------------------------------------
// vfd_sva
// Port-level checks of the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vfd_sva import vfd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] out_value,
	input logic [MODE_W-1:0]  out_kind,
	input logic [COUNT_W-1:0] out_count
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
		else $error("result dropped or changed while stalled");

	// raw bytes take exactly one byte and fit in eight bits
	a_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_BYTE |-> out_count == 4'd1 && out_value[63:8] == '0)
		else $error("raw byte result malformed");

	// int32 results keep the upper half clear
	a_i32: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_I32 |-> out_value[63:32] == '0)
		else $error("int32 result has upper bits set");

	// every result consumed at least one byte
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count != '0)
		else $error("result with zero byte count");

endmodule

bind varint_field_decoder vfd_sva u_vfd_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_value (result_out.value),
	.out_kind  (result_out.kind),
	.out_count (result_out.byte_count)
);
